### rtl/dtp_pkg.sv
package dtp_pkg;

	localparam logic [7:0]  CHAR_TERM  = 8'h00;
	localparam logic [7:0]  CHAR_MINUS = 8'h2D;
	localparam logic [7:0]  CHAR_ZERO  = 8'h30;
	localparam logic [7:0]  CHAR_NINE  = 8'h39;
	localparam logic [15:0] ACC_LIMIT  = 16'd65534;
	localparam logic [15:0] YEAR_BASE  = 16'd2000;
	localparam logic [2:0]  FIELD_COUNT = 3'd6;

	typedef enum logic [2:0] {
		FLD_YEAR   = 3'd0,
		FLD_MONTH  = 3'd1,
		FLD_DAY    = 3'd2,
		FLD_HOUR   = 3'd3,
		FLD_MINUTE = 3'd4,
		FLD_SECOND = 3'd5
	} field_t;

	typedef enum logic [1:0] {
		OUTCOME_DATE  = 2'd0,
		OUTCOME_ZERO  = 2'd1,
		OUTCOME_ONES  = 2'd2
	} outcome_t;

	// Character handed from the input register to the parser.
	typedef struct packed {
		logic       valid;
		logic [7:0] code;
	} dtp_char_t;

	// Result handed from the parser to the output register.
	typedef struct packed {
		logic        valid;
		logic [31:0] packed_time;
		outcome_t    outcome;
	} dtp_result_t;

	typedef struct packed {
		logic [15:0] acc;
		logic        have_digits;
		logic [2:0]  taken;
		logic [7:0]  year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic        range_err;
		logic        at_first;
		logic        minus;
	} dtp_state_t;

	localparam dtp_state_t STATE_RESET = '{
		acc: 16'd0, have_digits: 1'b0, taken: 3'd0, year: 8'd0, month: 4'd0,
		day: 5'd0, hour: 5'd0, minute: 6'd0, second: 6'd0, range_err: 1'b0,
		at_first: 1'b1, minus: 1'b0
	};

	// Days per month, with 29 allowed for February; codes outside 1..12 give 0.
	function automatic logic [4:0] month_days(input logic [3:0] m);
		logic [4:0] d;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                   d = 5'd30;
			4'd2:                                      d = 5'd29;
			default:                                   d = 5'd0;
		endcase
		return d;
	endfunction

endpackage

### rtl/dtp_in_reg.sv
module dtp_in_reg import dtp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       out_busy,
	output dtp_char_t  chr
);

	logic       valid_s1;
	logic [7:0] code_s1;
	logic       advance;
	logic       load;

	// Only a terminator needs room in the output register.
	assign advance  = !(code_s1 == CHAR_TERM && out_busy);
	assign in_stall = valid_s1 && !advance;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_s1 <= char_code;
		end
	end

	assign chr.valid = valid_s1 && advance;
	assign chr.code  = code_s1;

endmodule

### rtl/dtp_parse_core.sv
module dtp_parse_core import dtp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  dtp_char_t   chr,
	output dtp_result_t res
);

	dtp_state_t st_q;
	dtp_state_t st_d;

	// Stores one finished number into the next field and, for every field but the year, checks its range.
	function automatic dtp_state_t capture(input dtp_state_t s, input logic [15:0] v);
		dtp_state_t r;
		logic [15:0] yv;
		r  = s;
		yv = (v >= YEAR_BASE) ? v - YEAR_BASE : v;
		case (s.taken)
			FLD_YEAR: begin
				r.year = yv[7:0];
			end
			FLD_MONTH: begin
				if (v < 16'd1 || v > 16'd12) r.range_err = 1'b1;
				r.month = v[3:0];
			end
			FLD_DAY: begin
				if (v < 16'd1 || v > {11'd0, month_days(s.month)}) r.range_err = 1'b1;
				r.day = v[4:0];
			end
			FLD_HOUR: begin
				if (v > 16'd23) r.range_err = 1'b1;
				r.hour = v[4:0];
			end
			FLD_MINUTE: begin
				if (v > 16'd59) r.range_err = 1'b1;
				r.minute = v[5:0];
			end
			FLD_SECOND: begin
				if (v > 16'd59) r.range_err = 1'b1;
				r.second = v[5:0];
			end
			default: begin
			end
		endcase
		if (s.taken < FIELD_COUNT) r.taken = s.taken + 3'd1;
		return r;
	endfunction

	dtp_state_t  cap;
	logic        minus;
	logic [19:0] acc_next;
	logic [3:0]  m_fix;
	logic [4:0]  d_fix;

	always_comb begin
		st_d            = st_q;
		cap             = st_q;
		minus           = st_q.minus;
		acc_next        = 20'd0;
		m_fix           = st_q.month;
		d_fix           = st_q.day;
		res.valid       = 1'b0;
		res.packed_time = 32'd0;
		res.outcome     = OUTCOME_ZERO;
		if (chr.valid) begin
			minus       = st_q.minus || (st_q.at_first && chr.code == CHAR_MINUS);
			st_d.at_first = 1'b0;
			st_d.minus  = minus;
			if (chr.code == CHAR_TERM) begin
				res.valid = 1'b1;
				if (minus) begin
					res.packed_time = '1;
					res.outcome     = OUTCOME_ONES;
				end else begin
					if (st_q.have_digits && st_q.taken < FIELD_COUNT) begin
						cap = capture(st_q, st_q.acc);
					end
					m_fix = cap.month;
					d_fix = cap.day;
					// 29 February outside a leap year rolls over to 1 March.
					if (m_fix == 4'd2 && d_fix == 5'd29 && cap.year[1:0] != 2'd0) begin
						m_fix = 4'd3;
						d_fix = 5'd1;
					end
					if (cap.taken == FIELD_COUNT && !cap.range_err) begin
						res.packed_time = {cap.year[5:0], m_fix, d_fix, cap.hour,
							cap.minute, cap.second};
						res.outcome     = OUTCOME_DATE;
					end
				end
				st_d = STATE_RESET;
			end else if (!minus && st_q.taken < FIELD_COUNT) begin
				if (chr.code >= CHAR_ZERO && chr.code <= CHAR_NINE) begin
					acc_next = {16'd0, chr.code[3:0]};
					if (st_q.have_digits) begin
						acc_next = {1'b0, st_q.acc, 3'd0} + {3'd0, st_q.acc, 1'b0}
							+ {16'd0, chr.code[3:0]};
					end
					st_d.acc = (acc_next > {4'd0, ACC_LIMIT}) ? ACC_LIMIT : acc_next[15:0];
					st_d.have_digits = 1'b1;
				end else if (st_q.have_digits) begin
					st_d             = capture(st_q, st_q.acc);
					st_d.at_first    = 1'b0;
					st_d.acc         = 16'd0;
					st_d.have_digits = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else begin
			st_q <= st_d;
		end
	end

endmodule

### rtl/dtp_out_reg.sv
module dtp_out_reg import dtp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  dtp_result_t res,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] packed_time,
	output logic [1:0]  outcome
);

	logic        valid_q;
	logic [31:0] packed_q;
	outcome_t    outcome_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= res.valid || (valid_q && out_stall);
		end
	end

	// The input side holds back a terminator while this register is full and stalled.
	always_ff @(posedge clk) begin
		if (res.valid) begin
			packed_q  <= res.packed_time;
			outcome_q <= res.outcome;
		end
	end

	assign out_valid   = valid_q;
	assign packed_time = packed_q;
	assign outcome     = outcome_q;

endmodule

### rtl/datetime_text_parser.sv
// Date-time text parser: takes one character per cycle while the input is not
// stalled, with a zero byte ending the text, and gives one packed time word
// and an outcome code per text. The terminator of a text is registered in the
// input register, passes the parser, and its result is registered in the
// output register. The input stalls only when a terminator waits in the input
// register while the output register still holds an untaken, stalled result.
module datetime_text_parser import dtp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] packed_time,
	output logic [1:0]  outcome
);

	dtp_char_t   chr;
	dtp_result_t res;
	logic        out_busy;

	assign out_busy = out_valid && out_stall;

	dtp_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.out_busy  (out_busy),
		.chr       (chr)
	);

	dtp_parse_core u_parse_core (
		.clk    (clk),
		.arst_n (arst_n),
		.chr    (chr),
		.res    (res)
	);

	dtp_out_reg u_out_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.res         (res),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.packed_time (packed_time),
		.outcome     (outcome)
	);

endmodule
